>>> rtl/core/wbs_pkg.sv
// Shared constants, codes and stage records for the 3x3 blur/sharpen window filter.
// No dependencies; every other file of the block imports this package.
package wbs_pkg;

   localparam int MAX_WIDTH  = 1024;
   localparam int MAX_HEIGHT = 1024;
   localparam int MIN_DIM    = 3;

   localparam int COL_W     = $clog2(MAX_WIDTH);
   localparam int ROW_W     = $clog2(MAX_HEIGHT);
   localparam int CFG_W     = 11;
   localparam int PIX_W     = 8;
   localparam int WIN_N     = 9;
   localparam int SUM_W     = 12;
   localparam int CSR_IDX_W = 2;

   // Register indexes of the configuration port
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FILTER_MODE  = 2'd2;

   localparam logic [CFG_W-1:0] WIDTH_RESET  = 11'd100;
   localparam logic [CFG_W-1:0] HEIGHT_RESET = 11'd50;

   // Divide by nine as multiply by reciprocal; exact for sums up to 9*255
   localparam int DIV9_SHIFT = 16;
   localparam int DIV9_RECIP = 7282;

   localparam logic [PIX_W-1:0] PIX_MAX = 8'd255;

   // Where a result pixel comes from
   typedef enum logic [1:0] {
      SRC_UPPER_END,
      SRC_MIDDLE,
      SRC_CENTER,
      SRC_FILTER
   } src_type;

   typedef struct packed {
      logic             valid;
      logic             wr;
      logic             emit;
      src_type          src;
      logic             last;
      logic [COL_W-1:0] col;
      logic [PIX_W-1:0] pix;
   } stage1_type;

   typedef struct packed {
      logic [COL_W-1:0] top_addr;
      logic [COL_W-1:0] end_addr;
      logic [COL_W-1:0] mid_addr;
   } rdaddr_type;

   typedef struct packed {
      logic             valid;
      logic             filt;
      logic             last;
      logic [PIX_W-1:0] val;
      logic [SUM_W-1:0] sum;
      logic [PIX_W-1:0] ctr;
   } fin_type;

endpackage

>>> rtl/core/wbs_if.sv
// Valid/ready channel interfaces for the pixel input and the result output.
// Depends on wbs_pkg for the pixel width.
interface wbs_req_if import wbs_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [PIX_W-1:0] pixel_in;
   logic             drain;

   modport source (output valid, output pixel_in, output drain, input ready);
   modport sink   (input valid, input pixel_in, input drain, output ready);
endinterface

interface wbs_rsp_if import wbs_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [PIX_W-1:0] pixel_out;
   logic             frame_last;

   modport source (output valid, output pixel_out, output frame_last, input ready);
   modport sink   (input valid, input pixel_out, input frame_last, output ready);
endinterface

>>> rtl/core/wbs_ctrl.sv
// Configuration registers, raster position counters and per-pixel decisions.
// Depends on wbs_pkg and wbs_req_if; feeds the line buffers and the window stage.
module wbs_ctrl import wbs_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 run,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]     csr_wdata,
   wbs_req_if.sink              req_ch,
   output logic                 filter_mode,
   output rdaddr_type           rd_addr,
   output stage1_type           s1
);

   localparam int WC_W = (CFG_W > COL_W + 1) ? CFG_W : COL_W + 1;
   localparam int HC_W = (CFG_W > ROW_W + 1) ? CFG_W : ROW_W + 1;

   logic [CFG_W-1:0] width_ff;
   logic [CFG_W-1:0] height_ff;
   logic             mode_ff;
   logic [COL_W:0]   col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;
   logic             full_ff, full_in;
   stage1_type       s1_ff, s1_in;

   logic [COL_W:0] w, w_last, c, c_next, d, d_prev;
   logic [ROW_W:0] h, r, r_next;
   logic           accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
         mode_ff   <= 1'b0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_IMAGE_WIDTH:  width_ff  <= csr_wdata;
            CSR_IMAGE_HEIGHT: height_ff <= csr_wdata;
            CSR_FILTER_MODE:  mode_ff   <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // Clamp the frame size to the supported range
   always_comb begin
      if (WC_W'(width_ff) < WC_W'(MIN_DIM)) begin
         w = (COL_W+1)'(MIN_DIM);
      end else if (WC_W'(width_ff) > WC_W'(MAX_WIDTH)) begin
         w = (COL_W+1)'(MAX_WIDTH);
      end else begin
         w = (COL_W+1)'(width_ff);
      end
      if (HC_W'(height_ff) < HC_W'(MIN_DIM)) begin
         h = (ROW_W+1)'(MIN_DIM);
      end else if (HC_W'(height_ff) > HC_W'(MAX_HEIGHT)) begin
         h = (ROW_W+1)'(MAX_HEIGHT);
      end else begin
         h = (ROW_W+1)'(height_ff);
      end
   end

   assign w_last = w - 1'b1;
   assign c      = (col_ff >= w) ? w_last : col_ff;
   assign c_next = c + 1'b1;
   assign r      = ({1'b0, row_ff} >= h) ? h - 1'b1 : {1'b0, row_ff};
   assign r_next = r + 1'b1;
   assign d      = (col_ff > w) ? w : col_ff;
   assign d_prev = d - 1'b1;

   assign accept       = req_ch.valid && run;
   assign req_ch.ready = run;

   always_comb begin
      col_in    = col_ff;
      row_in    = row_ff;
      full_in   = full_ff;
      s1_in     = '0;
      s1_in.src = SRC_FILTER;
      s1_in.col = c[COL_W-1:0];
      s1_in.pix = req_ch.pixel_in;
      if (accept) begin
         if (full_ff) begin
            // Flush the last row and the last column pixel from the line buffers
            s1_in.valid = 1'b1;
            s1_in.emit  = 1'b1;
            s1_in.src   = (d == '0) ? SRC_UPPER_END : SRC_MIDDLE;
            s1_in.last  = (d == w);
            if (d == w) begin
               col_in  = '0;
               row_in  = '0;
               full_in = 1'b0;
            end else begin
               col_in = d + 1'b1;
            end
         end else if (!req_ch.drain) begin
            s1_in.valid = 1'b1;
            s1_in.wr    = 1'b1;
            if (c == '0 && r >= (ROW_W+1)'(2)) begin
               s1_in.emit = 1'b1;
               s1_in.src  = SRC_UPPER_END;
            end else if (c != '0 && r != '0) begin
               s1_in.emit = 1'b1;
               s1_in.src  = (r == (ROW_W+1)'(1) || c == (COL_W+1)'(1)) ?
                            SRC_CENTER : SRC_FILTER;
            end
            if (c_next >= w) begin
               col_in = '0;
               if (r_next >= h) begin
                  row_in  = '0;
                  full_in = 1'b1;
               end else begin
                  row_in = r_next[ROW_W-1:0];
               end
            end else begin
               col_in = c_next;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff      <= '0;
         row_ff      <= '0;
         full_ff     <= 1'b0;
         s1_ff.valid <= 1'b0;
      end else if (run) begin
         col_ff  <= col_in;
         row_ff  <= row_in;
         full_ff <= full_in;
         s1_ff   <= s1_in;
      end
   end

   assign rd_addr.top_addr = c[COL_W-1:0];
   assign rd_addr.end_addr = w_last[COL_W-1:0];
   assign rd_addr.mid_addr = full_ff ? d_prev[COL_W-1:0] : c[COL_W-1:0];

   assign s1          = s1_ff;
   assign filter_mode = mode_ff;

endmodule

>>> rtl/core/wbs_line_buf.sv
// Two line memories holding the previous two rows, with registered reads and
// write-to-read bypass. Depends on wbs_pkg.
module wbs_line_buf import wbs_pkg::*; (
   input  logic             clock,
   input  logic             run,
   input  rdaddr_type       rd_addr,
   input  stage1_type       s1,
   output logic [PIX_W-1:0] top,
   output logic [PIX_W-1:0] end_px,
   output logic [PIX_W-1:0] mid
);

   logic [PIX_W-1:0] upper_mem  [MAX_WIDTH];
   logic [PIX_W-1:0] middle_mem [MAX_WIDTH];

   logic [PIX_W-1:0] top_raw_ff, end_raw_ff, mid_raw_ff;
   logic             top_byp_ff, end_byp_ff, mid_byp_ff;
   logic [PIX_W-1:0] up_data_ff, pix_data_ff;
   logic             wr;

   assign wr = s1.valid && s1.wr;

   always_ff @(posedge clock) begin
      if (run) begin
         if (wr) begin
            // Age the column: middle row moves up, new pixel enters the middle row
            upper_mem[s1.col]  <= mid;
            middle_mem[s1.col] <= s1.pix;
         end
         top_raw_ff  <= upper_mem[rd_addr.top_addr];
         end_raw_ff  <= upper_mem[rd_addr.end_addr];
         mid_raw_ff  <= middle_mem[rd_addr.mid_addr];
         top_byp_ff  <= wr && (rd_addr.top_addr == s1.col);
         end_byp_ff  <= wr && (rd_addr.end_addr == s1.col);
         mid_byp_ff  <= wr && (rd_addr.mid_addr == s1.col);
         up_data_ff  <= mid;
         pix_data_ff <= s1.pix;
      end
   end

   assign top    = top_byp_ff ? up_data_ff  : top_raw_ff;
   assign end_px = end_byp_ff ? up_data_ff  : end_raw_ff;
   assign mid    = mid_byp_ff ? pix_data_ff : mid_raw_ff;

endmodule

>>> rtl/core/wbs_window.sv
// 3x3 sliding window registers, result source selection and the window sum stage.
// Depends on wbs_pkg; takes the line buffer read data.
module wbs_window import wbs_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             run,
   input  stage1_type       s1,
   input  logic [PIX_W-1:0] top,
   input  logic [PIX_W-1:0] mid,
   input  logic [PIX_W-1:0] end_px,
   output fin_type          fin
);

   logic [PIX_W-1:0] win_ff [WIN_N];
   logic             s2_valid_ff, s2_filt_ff, s2_last_ff;
   logic [PIX_W-1:0] s2_val_ff;
   fin_type          fin_ff;
   logic [PIX_W-1:0] pick;
   logic [SUM_W-1:0] sum;

   // Window index 4 is the center; index 5 becomes the center after a shift
   always_comb begin
      case (s1.src)
         SRC_UPPER_END: pick = end_px;
         SRC_MIDDLE:    pick = mid;
         SRC_CENTER:    pick = win_ff[5];
         default:       pick = '0;
      endcase
   end

   always_comb begin
      sum = '0;
      for (int i = 0; i < WIN_N; i++) begin
         sum = sum + SUM_W'(win_ff[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < WIN_N; i++) begin
            win_ff[i] <= '0;
         end
         s2_valid_ff  <= 1'b0;
         fin_ff.valid <= 1'b0;
      end else if (run) begin
         if (s1.valid && s1.wr) begin
            for (int k = 0; k < 3; k++) begin
               win_ff[3*k]     <= win_ff[3*k + 1];
               win_ff[3*k + 1] <= win_ff[3*k + 2];
            end
            win_ff[2] <= top;
            win_ff[5] <= mid;
            win_ff[8] <= s1.pix;
         end
         s2_valid_ff <= s1.valid && s1.emit;
         s2_filt_ff  <= (s1.src == SRC_FILTER);
         s2_last_ff  <= s1.last;
         s2_val_ff   <= pick;

         fin_ff.valid <= s2_valid_ff;
         fin_ff.filt  <= s2_filt_ff;
         fin_ff.last  <= s2_last_ff;
         fin_ff.val   <= s2_val_ff;
         fin_ff.sum   <= sum;
         fin_ff.ctr   <= win_ff[4];
      end
   end

   assign fin = fin_ff;

endmodule

>>> rtl/core/wbs_filter.sv
// Final arithmetic: truncated mean or clamped sharpen from the window sum and center.
// Depends on wbs_pkg; purely combinational.
module wbs_filter import wbs_pkg::*; (
   input  fin_type          fin,
   input  logic             filter_mode,
   output logic             res_valid,
   output logic [PIX_W-1:0] res_pixel,
   output logic             res_last
);

   localparam int PROD_W = SUM_W + DIV9_SHIFT;
   localparam int DIFF_W = SUM_W + 2;

   logic [PROD_W-1:0]        prod;
   logic [PIX_W-1:0]         mean;
   logic signed [DIFF_W-1:0] diff;
   logic [PIX_W-1:0]         sharp;

   assign prod = PROD_W'(fin.sum) * PROD_W'(DIV9_RECIP);
   assign mean = prod[DIV9_SHIFT +: PIX_W];

   // Ten times the center minus the full sum: nine times center minus neighbours
   assign diff = $signed(DIFF_W'({fin.ctr, 3'b000})) + $signed(DIFF_W'({fin.ctr, 1'b0}))
               - $signed(DIFF_W'(fin.sum));

   always_comb begin
      if (diff < 0) begin
         sharp = '0;
      end else if (diff > $signed(DIFF_W'(PIX_MAX))) begin
         sharp = PIX_MAX;
      end else begin
         sharp = diff[PIX_W-1:0];
      end
   end

   always_comb begin
      if (!fin.filt) begin
         res_pixel = fin.val;
      end else if (filter_mode) begin
         res_pixel = sharp;
      end else begin
         res_pixel = mean;
      end
   end

   assign res_valid = fin.valid;
   assign res_last  = fin.last;

endmodule

>>> rtl/core/wbs_out_buf.sv
// Result register with a skid stage; its fill state gates the whole pipeline.
// Depends on wbs_pkg and wbs_rsp_if.
module wbs_out_buf import wbs_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             res_valid,
   input  logic [PIX_W-1:0] res_pixel,
   input  logic             res_last,
   output logic             run,
   wbs_rsp_if.source        rsp_ch
);

   logic             out_valid_ff, skid_valid_ff;
   logic [PIX_W-1:0] out_pixel_ff, skid_pixel_ff;
   logic             out_last_ff, skid_last_ff;
   logic             push, taken;

   assign run   = !skid_valid_ff;
   assign push  = run && res_valid;
   assign taken = out_valid_ff && rsp_ch.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (!out_valid_ff || taken) begin
            if (skid_valid_ff) begin
               out_valid_ff  <= 1'b1;
               out_pixel_ff  <= skid_pixel_ff;
               out_last_ff   <= skid_last_ff;
               skid_valid_ff <= 1'b0;
            end else begin
               out_valid_ff <= push;
               out_pixel_ff <= res_pixel;
               out_last_ff  <= res_last;
            end
         end else if (push) begin
            // Park the result while the output stalls
            skid_valid_ff <= 1'b1;
            skid_pixel_ff <= res_pixel;
            skid_last_ff  <= res_last;
         end
      end
   end

   assign rsp_ch.valid      = out_valid_ff;
   assign rsp_ch.pixel_out  = out_pixel_ff;
   assign rsp_ch.frame_last = out_last_ff;

endmodule

>>> rtl/core/window3x3_blur_sharpen.sv
// 3x3 box blur / sharpen over a raster stream of 8-bit grey pixels.
// A result is carried by the stage-1, stage-2 and sum registers into the output register.
// Throughput: one input transfer per cycle unless stalled; the result register plus skid
// stage keep the input open while a finished result waits; each line memory serves one
// write and up to two reads per cycle. Reset (synchronous): 100x50 frame, blur, counters
// and window cleared; line memories keep their contents and need no clearing pass.
module window3x3_blur_sharpen import wbs_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]     csr_wdata,
   wbs_req_if.sink              req_ch,
   wbs_rsp_if.source            rsp_ch
);

   logic             run;
   logic             filter_mode;
   rdaddr_type       rd_addr;
   stage1_type       s1;
   logic [PIX_W-1:0] top, mid, end_px;
   fin_type          fin;
   logic             res_valid;
   logic [PIX_W-1:0] res_pixel;
   logic             res_last;

   // Stage 0: decide what each transfer does, advance the raster position,
   // and address the line memories.
   wbs_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .run         (run),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .req_ch      (req_ch),
      .filter_mode (filter_mode),
      .rd_addr     (rd_addr),
      .s1          (s1)
   );

   // Stage 1: read data of the two previous rows arrives; write the column back
   // aged by one row. Bypass covers a read of the entry written in the same cycle.
   wbs_line_buf u_line_buf (
      .clock   (clock),
      .run     (run),
      .rd_addr (rd_addr),
      .s1      (s1),
      .top     (top),
      .end_px  (end_px),
      .mid     (mid)
   );

   // Stages 1 and 2: slide the window, pick border pass-through values,
   // then register the nine-pixel sum and the center.
   wbs_window u_window (
      .clock  (clock),
      .reset  (reset),
      .run    (run),
      .s1     (s1),
      .top    (top),
      .mid    (mid),
      .end_px (end_px),
      .fin    (fin)
   );

   // Stage 3: mean by reciprocal multiply, sharpen with clamp, or border pass-through.
   wbs_filter u_filter (
      .fin         (fin),
      .filter_mode (filter_mode),
      .res_valid   (res_valid),
      .res_pixel   (res_pixel),
      .res_last    (res_last)
   );

   // Output register and skid; hold every stage while the skid is occupied.
   wbs_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .res_valid (res_valid),
      .res_pixel (res_pixel),
      .res_last  (res_last),
      .run       (run),
      .rsp_ch    (rsp_ch)
   );

endmodule

>>> sim/testbench.sv
// Self-checking bench for the 3x3 blur/sharpen window filter: a line-buffer predictor
// tracks every accepted transfer and compares each result in order.
// Depends on wbs_pkg, the wbs_req_if/wbs_rsp_if channels and window3x3_blur_sharpen.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import wbs_pkg::*;

   localparam int RANDOM_ITEMS  = 1100;
   localparam int SETTLE_CYCLES = 10;      // pipeline depth to the output register, with margin
   localparam int HOLD_CYCLES   = 300;     // long result back-pressure stretch
   localparam int CYCLE_LIMIT   = 1000000;

   // One expected result transfer
   typedef struct {
      logic [PIX_W-1:0] pix;
      logic             last;
   } out_pixel_type;

   typedef enum {
      PACE_STEADY,
      PACE_SENDER_IDLE,
      PACE_RECEIVER_STALL,
      PACE_BOTH
   } pace_kind_type;

   // Line-buffer predictor plus the queue of results it has promised
   class blur_sharpen_tracker;
      logic [CFG_W-1:0] width_reg;
      logic [CFG_W-1:0] height_reg;
      logic             mode_reg;
      logic [PIX_W-1:0] upper_row [MAX_WIDTH];
      logic [PIX_W-1:0] middle_row [MAX_WIDTH];
      logic [PIX_W-1:0] win [WIN_N];
      int               col;
      int               row;
      bit               frame_full;
      out_pixel_type    pixels_due [$];
      int               errors;

      function new();
         width_reg  = WIDTH_RESET;
         height_reg = HEIGHT_RESET;
         mode_reg   = 1'b0;
         foreach (upper_row[i]) begin
            upper_row[i]  = '0;
            middle_row[i] = '0;
         end
         foreach (win[i]) win[i] = '0;
         col        = 0;
         row        = 0;
         frame_full = 0;
         errors     = 0;
      endfunction

      function int clamp_dim(int v, int hi);
         if (v < MIN_DIM) return MIN_DIM;
         if (v > hi) return hi;
         return v;
      endfunction

      function int eff_width();
         return clamp_dim(width_reg, MAX_WIDTH);
      endfunction

      function int eff_height();
         return clamp_dim(height_reg, MAX_HEIGHT);
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
         case (idx)
            CSR_IMAGE_WIDTH:  width_reg  = data;
            CSR_IMAGE_HEIGHT: height_reg = data;
            CSR_FILTER_MODE:  mode_reg   = data[0];
            default: ;
         endcase
      endfunction

      // Mean of the window, or 9x center minus neighbours clamped to a pixel
      function logic [PIX_W-1:0] window_value();
         int sum;
         int v;
         sum = 0;
         foreach (win[i]) sum += win[i];
         if (mode_reg == 1'b0) return PIX_W'(sum / WIN_N);
         v = 10 * int'(win[4]) - sum;
         if (v < 0) v = 0;
         if (v > PIX_MAX) v = PIX_MAX;
         return v[PIX_W-1:0];
      endfunction

      function void take_item(logic [PIX_W-1:0] pix, logic drain);
         int               w;
         int               h;
         int               c;
         int               r;
         logic [PIX_W-1:0] val;
         logic [PIX_W-1:0] top;
         logic [PIX_W-1:0] mid;
         bit               emit;
         bit               is_last;
         w       = eff_width();
         h       = eff_height();
         val     = '0;
         emit    = 0;
         is_last = 0;
         if (frame_full) begin
            // flush phase: any item pushes out one pending pixel of the last two rows
            if (col > w) col = w;
            if (col == 0) val = upper_row[w-1];
            else val = middle_row[col-1];
            emit = 1;
            if (col >= w) begin
               is_last    = 1;
               col        = 0;
               row        = 0;
               frame_full = 0;
            end else begin
               col++;
            end
         end else begin
            if (drain) return;
            if (col >= w) col = w - 1;
            if (row >= h) row = h - 1;
            c = col;
            r = row;
            if (c == 0 && r >= 2) begin
               val  = upper_row[w-1];
               emit = 1;
            end
            top           = upper_row[c];
            mid           = middle_row[c];
            upper_row[c]  = mid;
            middle_row[c] = pix;
            for (int i = 0; i < 3; i++) begin
               win[3*i]   = win[3*i+1];
               win[3*i+1] = win[3*i+2];
            end
            win[2] = top;
            win[5] = mid;
            win[8] = pix;
            if (c >= 1 && r >= 1) begin
               val  = (r == 1 || c == 1) ? win[4] : window_value();
               emit = 1;
            end
            if (c + 1 >= w) begin
               col = 0;
               if (r + 1 >= h) begin
                  row        = 0;
                  frame_full = 1;
               end else begin
                  row = r + 1;
               end
            end else begin
               col = c + 1;
            end
         end
         if (emit) pixels_due.push_back('{pix: val, last: is_last});
      endfunction

      function void complain(string msg);
         errors++;
         $display("%0t: %s", $time, msg);
      endfunction

      function void match_pixel(logic [PIX_W-1:0] pix, logic last);
         out_pixel_type want;
         if (pixels_due.size() == 0) begin
            complain($sformatf("unexpected result: expected none, got pixel_out %0d frame_last %0b",
                               pix, last));
            return;
         end
         want = pixels_due.pop_front();
         if (pix !== want.pix)
            complain($sformatf("pixel_out: expected %0d, got %0d", want.pix, pix));
         if (last !== want.last)
            complain($sformatf("frame_last: expected %0b, got %0b", want.last, last));
      endfunction
   endclass

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CFG_W-1:0]     csr_wdata;

   wbs_req_if req_ch ();
   wbs_rsp_if rsp_ch ();

   blur_sharpen_tracker tracker = new();

   int idle_pct;       // chance in 100 that the sender skips a cycle
   int stall_pct;      // chance in 100 that the receiver drops ready
   int items_sent;     // transfers that move the frame along (ignored drains left out)
   int cycle_count;
   bit hold_armed;     // set by the stimulus, consumed by the receiver
   bit hold_used;
   int hold_left;

   window3x3_blur_sharpen DUT (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch)
   );

   always #2 clock = ~clock;

   // Give up on a hung block
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // Result side: check every transfer, then pick ready for the next edge.
   // A requested hold-off is counted here so the sender keeps pushing meanwhile.
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready)
         tracker.match_pixel(rsp_ch.pixel_out, rsp_ch.frame_last);
      if (hold_armed && !hold_used) begin
         hold_used = 1;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   task automatic set_pacing(input pace_kind_type kind);
      case (kind)
         PACE_STEADY: begin
            idle_pct  = 0;
            stall_pct = 0;
         end
         PACE_SENDER_IDLE: begin
            idle_pct  = 59;
            stall_pct = 0;
         end
         PACE_RECEIVER_STALL: begin
            idle_pct  = 0;
            stall_pct = 59;
         end
         default: begin
            idle_pct  = 17;
            stall_pct = 17;
         end
      endcase
   endtask

   // Offer one item after random idle cycles, hold it until the transfer, then
   // advance the predictor. valid stays high so back-to-back items need no gap.
   task automatic send_item(input logic [PIX_W-1:0] pix, input logic drain);
      while ($urandom_range(99) < idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid    <= 1'b1;
      req_ch.pixel_in <= pix;
      req_ch.drain    <= drain;
      do @(posedge clock); while (!(req_ch.valid && req_ch.ready));
      if (tracker.frame_full || !drain) items_sent++;
      tracker.take_item(pix, drain);
   endtask

   // Drop valid and let every promised result drain, plus the pipeline depth,
   // since pixels of the first row make no result but may still be in flight.
   task automatic settle();
      req_ch.valid <= 1'b0;
      while (tracker.pixels_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Write width, height and mode back to back; a negative value skips that register.
   // Mode writes carry random upper bits, which the block must ignore.
   task automatic program_filter(input int w, input int h, input int mode);
      int                   vals [3];
      logic [CSR_IDX_W-1:0] idx  [3];
      logic [CFG_W-1:0]     data;
      vals = '{w, h, mode};
      idx  = '{CSR_IMAGE_WIDTH, CSR_IMAGE_HEIGHT, CSR_FILTER_MODE};
      for (int k = 0; k < 3; k++) begin
         if (vals[k] >= 0) begin
            data = CFG_W'(vals[k]);
            if (idx[k] == CSR_FILTER_MODE)
               data = {10'($urandom_range(1023)), 1'(vals[k])};
            csr_we    <= 1'b1;
            csr_index <= idx[k];
            csr_wdata <= data;
            @(posedge clock);
            tracker.write_reg(idx[k], data);
         end
      end
      csr_we <= 1'b0;
   endtask

   // Push out the pending last row; drains and stray pixels both act as flush items
   task automatic drain_frame();
      while (tracker.frame_full)
         send_item(PIX_W'($urandom_range(255)), 1'($urandom_range(1)));
   endtask

   // One frame of pixels: random, black/white only, or flat. Sprinkle drains that the
   // block must ignore, and now and then shrink a dimension or flip the mode mid-frame.
   task automatic stream_frame(input int style, input bit may_retune);
      logic [PIX_W-1:0] flat;
      bit               retuned;
      int               pick;
      flat    = PIX_W'($urandom_range(255));
      retuned = 0;
      while (!tracker.frame_full) begin
         if ($urandom_range(19) == 0) send_item(PIX_W'($urandom_range(255)), 1'b1);
         if (may_retune && !retuned && $urandom_range(149) == 0) begin
            retuned = 1;
            settle();
            pick = $urandom_range(2);
            // only shrink: a grown row would read line entries this frame never wrote
            if (pick == 0) program_filter($urandom_range(tracker.eff_width()), -1, -1);
            else if (pick == 1) program_filter(-1, $urandom_range(tracker.eff_height()), -1);
            else program_filter(-1, -1, !tracker.mode_reg);
         end
         case (style)
            0:       send_item(PIX_W'($urandom_range(255)), 1'b0);
            1:       send_item($urandom_range(1) ? PIX_MAX : 8'd0, 1'b0);
            default: send_item(flat, 1'b0);
         endcase
      end
      drain_frame();
   endtask

   initial begin
      logic [PIX_W-1:0] sharpen_pix [12];
      int               frame_no;
      int               w_pick;
      int               h_pick;
      // 3 wide, 4 tall: the upper inner pixel saturates high, the lower one low
      sharpen_pix = '{8'd0,   8'd0,   8'd0,
                      8'd0,   8'd255, 8'd0,
                      8'd0,   8'd0,   8'd0,
                      8'd255, 8'd255, 8'd255};
      req_ch.valid    <= 1'b0;
      req_ch.pixel_in <= '0;
      req_ch.drain    <= 1'b0;
      csr_we          <= 1'b0;
      csr_index       <= CSR_IMAGE_WIDTH;
      csr_wdata       <= '0;
      reset           <= 1'b1;
      items_sent = 0;
      hold_armed = 0;
      hold_used = 0;
      hold_left = 0;
      set_pacing(PACE_STEADY);
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed: drain on an empty frame is ignored, then a sharpen frame
      // that hits both clamps, then a bright blur frame with the largest sum.
      program_filter(3, 4, 1);
      send_item(PIX_W'($urandom_range(255)), 1'b1);
      foreach (sharpen_pix[i]) send_item(sharpen_pix[i], 1'b0);
      drain_frame();
      settle();
      program_filter(-1, 3, 0);
      repeat (9) send_item(PIX_MAX, 1'b0);
      drain_frame();

      // Random frames, mostly small, under changing pacing
      frame_no = 0;
      while (items_sent < RANDOM_ITEMS) begin
         if (frame_no == 5) begin
            // hold off the receiver on a wider frame so the block backs up
            settle();
            program_filter(10, 8, $urandom_range(1));
            set_pacing(PACE_STEADY);
            hold_armed = 1;
            stream_frame(0, 0);
         end else begin
            set_pacing(pace_kind_type'($urandom_range(3)));
            if ($urandom_range(2) != 0) begin
               w_pick = ($urandom_range(9) == 0) ? $urandom_range(2) : $urandom_range(3, 10);
               h_pick = ($urandom_range(9) == 0) ? $urandom_range(2) : $urandom_range(3, 8);
               settle();
               program_filter(w_pick, h_pick, $urandom_range(1));
            end
            stream_frame($urandom_range(2), 1);
         end
         frame_no++;
      end

      // Oversize width and height clamp to the largest frame; part way into the
      // first row, shrink to a small frame and finish it
      settle();
      set_pacing(pace_kind_type'($urandom_range(3)));
      program_filter(2047, 2047, $urandom_range(1));
      repeat (40) send_item(PIX_W'($urandom_range(255)), 1'b0);
      settle();
      program_filter(8, 4, -1);
      stream_frame(0, 0);

      settle();
      if (tracker.errors == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end
endmodule

>>> files.f
rtl/core/wbs_pkg.sv
rtl/core/wbs_if.sv
rtl/core/wbs_ctrl.sv
rtl/core/wbs_line_buf.sv
rtl/core/wbs_window.sv
rtl/core/wbs_filter.sv
rtl/core/wbs_out_buf.sv
rtl/core/window3x3_blur_sharpen.sv
sim/testbench.sv
